>>> rtl/core/assert_macros.svh
// assertion macros shared by the scheduler rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define RRTS_ASSERT_NEVER(lbl, cond, msg) \
  `RRTS_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/rrts_pkg.sv
// shared types and constants of the round-robin task scheduler
// no dependencies; used by rrts_ctrl, rrts_dp and the top level
package rrts_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_YIELD  = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // slice interval after reset, in ns
  localparam logic [31:0] IntervalReset = 32'd1000000;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    slice_add;
    logic    rot_rd;
    logic    rot_wr;
    logic    scan;
    logic    append;
    logic    sh_rd;
    logic    sh_wr;
    logic    remove_fin;
    logic    head_rd;
    logic    set_status;
    status_e status;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic slice_due;
    logic hit;
    logic scan_done;
    logic at_last;
  } dp_stat_t;

endpackage

>>> rtl/core/rrts_ctrl.sv
// sequencing state machine of the round-robin task scheduler
// depends on rrts_pkg and assert_macros.svh
`include "assert_macros.svh"

module rrts_ctrl import rrts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] mode_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic       busy,
  output logic       done_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TICK_ADD = 4'd1;
  localparam logic [3:0] S_TICK_CMP = 4'd2;
  localparam logic [3:0] S_ROT_RD   = 4'd3;
  localparam logic [3:0] S_ROT_WR   = 4'd4;
  localparam logic [3:0] S_SRCH     = 4'd5;
  localparam logic [3:0] S_SH_CHK   = 4'd6;
  localparam logic [3:0] S_SH_RD    = 4'd7;
  localparam logic [3:0] S_SH_WR    = 4'd8;
  localparam logic [3:0] S_HEAD_RD  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_q, state_d;
  mode_e      mode_q, mode_in;

  assign mode_in = mode_e'(mode_i);

  // state and operation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_TICK;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start) begin
        mode_q <= mode_in;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (mode_in) inside
            MODE_TICK:             state_d = S_TICK_ADD;
            MODE_YIELD:            state_d = stat_i.count_zero ? S_HEAD_RD : S_ROT_RD;
            MODE_ADD, MODE_REMOVE: state_d = S_SRCH;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_TICK_ADD: begin
        if (stat_i.count_zero) begin
          state_d = S_HEAD_RD;
        end else begin
          cmd_o.slice_add = 1'b1;
          state_d = S_TICK_CMP;
        end
      end
      S_TICK_CMP: begin
        state_d = stat_i.slice_due ? S_ROT_RD : S_HEAD_RD;
      end
      S_ROT_RD: begin
        cmd_o.rot_rd = 1'b1;
        state_d = S_ROT_WR;
      end
      S_ROT_WR: begin
        cmd_o.rot_wr = 1'b1;
        state_d = S_HEAD_RD;
      end
      S_SRCH: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          if (mode_q == MODE_ADD) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_DUP;
            state_d = S_HEAD_RD;
          end else begin
            state_d = S_SH_CHK;
          end
        end else if (stat_i.scan_done) begin
          state_d = S_HEAD_RD;
          if (mode_q == MODE_ADD) begin
            if (stat_i.count_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.append = 1'b1;
            end
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_MISSING;
          end
        end
      end
      S_SH_CHK: begin
        if (stat_i.at_last) begin
          cmd_o.remove_fin = 1'b1;
          state_d = S_HEAD_RD;
        end else begin
          cmd_o.sh_rd = 1'b1;
          state_d = S_SH_WR;
        end
      end
      S_SH_RD: begin
        cmd_o.sh_rd = 1'b1;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d = S_SH_CHK;
      end
      S_HEAD_RD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // checks
  `RRTS_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `RRTS_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not make the block busy")
  `RRTS_ASSERT_NEVER(a_wr_clash, cmd_o.append && (cmd_o.rot_wr || cmd_o.sh_wr), "two queue writes")

endmodule

>>> rtl/core/rrts_dp.sv
// datapath of the round-robin task scheduler: ring memory, pointers, slice counter
// depends on rrts_pkg and assert_macros.svh
`include "assert_macros.svh"

module rrts_dp import rrts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int ID_WIDTH  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] elapsed_ns_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic [7:0]  running_task_o,
  output logic        running_valid_o,
  output logic [4:0]  task_count_o,
  output logic        switched_o,
  output logic [1:0]  status_o
);

  localparam int PW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [PW-1:0] LastPtr = PW'(MAX_TASKS - 1);

  // ring pointer step forward and back with wrap
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LastPtr) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? LastPtr : p - PW'(1);
  endfunction

  logic [ID_WIDTH-1:0] task_mem_q [MAX_TASKS];
  logic [ID_WIDTH-1:0] rdata_q;
  logic [31:0]         interval_q;
  logic [32:0]         slice_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       scan_idx_q;
  logic [PW-1:0]       head_q, tail_q, scan_ptr_q, pend_ptr_q, cursor_q;
  logic                pend_q;
  logic                switched_q;
  status_e             status_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [31:0]         elapsed_q;

  logic [ID_WIDTH+7:0] id_ext, run_ext;
  logic [CW+4:0]       count_ext;
  logic                scan_issue;
  logic                wr_en, rd_en;
  logic [PW-1:0]       wr_addr, rd_addr;
  logic [ID_WIDTH-1:0] wr_data;

  assign id_ext     = (ID_WIDTH + 8)'(task_id_i);
  assign scan_issue = cmd_i.scan && (scan_idx_q != count_q);

  // status toward the controller
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_full = (count_q == CW'(MAX_TASKS));
  assign stat_o.slice_due  = (slice_q >= {1'b0, interval_q});
  assign stat_o.hit        = pend_q && (rdata_q == id_q);
  assign stat_o.scan_done  = !pend_q && (scan_idx_q == count_q);
  assign stat_o.at_last    = (cursor_q == ptr_dec(tail_q));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      slice_q    <= '0;
      count_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
      switched_q <= 1'b0;
      status_q   <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        switched_q <= 1'b0;
        status_q   <= ST_OK;
        scan_idx_q <= '0;
        pend_q     <= 1'b0;
      end
      if (cmd_i.slice_add) begin
        slice_q <= slice_q + {1'b0, elapsed_q};
      end
      if (cmd_i.rot_wr) begin
        head_q     <= ptr_inc(head_q);
        tail_q     <= ptr_inc(tail_q);
        slice_q    <= '0;
        switched_q <= 1'b1;
      end
      if (cmd_i.scan) begin
        scan_idx_q <= scan_issue ? scan_idx_q + CW'(1) : scan_idx_q;
        pend_q     <= scan_issue;
      end
      if (cmd_i.append) begin
        tail_q  <= ptr_inc(tail_q);
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.remove_fin) begin
        tail_q  <= ptr_dec(tail_q);
        count_q <= count_q - CW'(1);
        if (count_q == CW'(1)) begin
          slice_q <= '0;
        end
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
  end

  // item payload and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q       <= id_ext[ID_WIDTH-1:0];
      elapsed_q  <= elapsed_ns_i;
      scan_ptr_q <= head_q;
    end
    if (scan_issue) begin
      scan_ptr_q <= ptr_inc(scan_ptr_q);
      pend_ptr_q <= scan_ptr_q;
    end
    if (cmd_i.scan && stat_o.hit) begin
      cursor_q <= pend_ptr_q;
    end
    if (cmd_i.sh_wr) begin
      cursor_q <= ptr_inc(cursor_q);
    end
  end

  // memory port selection
  always_comb begin
    wr_en   = cmd_i.rot_wr || cmd_i.append || cmd_i.sh_wr;
    wr_addr = cmd_i.sh_wr ? cursor_q : tail_q;
    wr_data = cmd_i.append ? id_q : rdata_q;
    rd_en   = cmd_i.rot_rd || cmd_i.head_rd || scan_issue || cmd_i.sh_rd;
    if (cmd_i.sh_rd) begin
      rd_addr = ptr_inc(cursor_q);
    end else if (cmd_i.scan) begin
      rd_addr = scan_ptr_q;
    end else begin
      rd_addr = head_q;
    end
  end

  // task ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      task_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= task_mem_q[rd_addr];
    end
  end

  // result fields
  assign run_ext         = (ID_WIDTH + 8)'(rdata_q);
  assign count_ext       = (CW + 5)'(count_q);
  assign running_valid_o = (count_q != '0);
  assign running_task_o  = running_valid_o ? run_ext[7:0] : 8'd0;
  assign task_count_o    = count_ext[4:0];
  assign switched_o      = switched_q;
  assign status_o        = status_q;

  // checks
  `RRTS_ASSERT(a_count_range, count_q <= CW'(MAX_TASKS), "task count above capacity")
  `RRTS_ASSERT(a_empty_slice, (count_q == '0) |-> (slice_q == '0), "slice time kept on empty ring")
  `RRTS_ASSERT(a_scan_bound, cmd_i.scan |-> (scan_idx_q <= count_q), "search ran past the tasks")

endmodule

>>> rtl/core/round_robin_task_scheduler_core.sv
// top level of the round-robin task scheduler: controller plus datapath
// depends on rrts_pkg, rrts_ctrl and rrts_dp
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------------
//  item in   | start, busy                 | mode_i, task_id_i, elapsed_ns_i
//  result    | done_o (one-cycle strobe)   | running_task_o, running_valid_o,
//            |                             | task_count_o, switched_o, status_o
//  config    | switch_interval_ns_we_i     | switch_interval_ns_i
//
// tick and yield do not depend on the task count; add and remove grow with it,
// set by the walk of the ring memory with its one read and one write port (one
// entry per cycle on search, a read then a write per entry on close-up); busy is
// high from the accept edge through the done_o cycle.
// reset clears the ring to empty and loads the interval with 1000000 ns.
// results cannot be held off: each is valid only in the done_o cycle.
module round_robin_task_scheduler_core import rrts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int ID_WIDTH  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        switch_interval_ns_we_i,
  input  logic [31:0] switch_interval_ns_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] elapsed_ns_i,
  output logic        done_o,
  output logic [7:0]  running_task_o,
  output logic        running_valid_o,
  output logic [4:0]  task_count_o,
  output logic        switched_o,
  output logic [1:0]  status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // ring, counters and result fields
  rrts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .ID_WIDTH  (ID_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (switch_interval_ns_we_i),
    .cfg_wdata_i     (switch_interval_ns_i),
    .task_id_i       (task_id_i),
    .elapsed_ns_i    (elapsed_ns_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .running_task_o  (running_task_o),
    .running_valid_o (running_valid_o),
    .task_count_o    (task_count_o),
    .switched_o      (switched_o),
    .status_o        (status_o)
  );

endmodule

>>> tb/rrts_sched_checker.sv
`timescale 1ns / 1ps
// result checker for the round-robin task scheduler: mirrors the task ring,
// predicts one result per accepted item and compares every done_o strobe
// depends on rrts_pkg for the mode and status codes
module rrts_sched_checker import rrts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] elapsed_ns_i,
  input  logic        done_i,
  input  logic [7:0]  running_task_i,
  input  logic        running_valid_i,
  input  logic [4:0]  task_count_i,
  input  logic        switched_i,
  input  logic [1:0]  status_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [7:0] task_id;
    logic       valid;
    logic [4:0] count;
    logic       switched;
    status_e    status;
  } sched_result_t;

  // mirrored scheduler state
  logic [7:0]    ring_q [MAX_TASKS];
  int unsigned   ring_count  = 0;
  logic [32:0]   slice_ns    = '0;
  logic [31:0]   interval_ns = IntervalReset;

  sched_result_t expected_q [$];
  sched_result_t oldest;
  int            mismatch_count = 0;
  int            pending_count  = 0;
  int unsigned   results_seen   = 0;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = pending_count;

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  function automatic int find_task(logic [7:0] id);
    int i;
    for (i = 0; i < ring_count; i++) begin
      if (ring_q[i] == id) return i;
    end
    return -1;
  endfunction

  // head goes to the back, slice restarts
  function automatic void rotate_ring();
    logic [7:0] head;
    int         i;
    if (ring_count == 0) return;
    head = ring_q[0];
    for (i = 1; i < ring_count; i++) ring_q[i-1] = ring_q[i];
    ring_q[ring_count-1] = head;
    slice_ns = '0;
  endfunction

  // apply one item to the mirrored ring and build its result
  function automatic sched_result_t schedule_item(mode_e mode, logic [7:0] id,
                                                  logic [31:0] elapsed);
    sched_result_t res;
    int            pos;
    int            i;
    res        = '0;
    res.status = ST_OK;
    case (mode)
      MODE_TICK: begin
        // an empty ring does not accumulate time
        if (ring_count != 0) begin
          slice_ns = slice_ns + {1'b0, elapsed};
          if (slice_ns >= {1'b0, interval_ns}) begin
            rotate_ring();
            res.switched = 1'b1;
          end
        end
      end
      MODE_ADD: begin
        // duplicate check wins over full
        if (find_task(id) >= 0) begin
          res.status = ST_DUP;
        end else if (ring_count >= MAX_TASKS) begin
          res.status = ST_FULL;
        end else begin
          ring_q[ring_count] = id;
          ring_count++;
        end
      end
      MODE_REMOVE: begin
        pos = find_task(id);
        if (pos < 0) begin
          res.status = ST_MISSING;
        end else begin
          for (i = pos + 1; i < ring_count; i++) ring_q[i-1] = ring_q[i];
          ring_count--;
          if (ring_count == 0) slice_ns = '0;
        end
      end
      default: begin
        if (ring_count != 0) begin
          rotate_ring();
          res.switched = 1'b1;
        end
      end
    endcase
    res.valid   = (ring_count != 0);
    res.task_id = res.valid ? ring_q[0] : 8'd0;
    res.count   = ring_count[4:0];
    return res;
  endfunction

  // compare results, track register writes, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count    = 0;
      slice_ns      = '0;
      interval_ns   = IntervalReset;
      expected_q.delete();
      pending_count = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          oldest = expected_q.pop_front();
          if (running_task_i !== oldest.task_id)
            report_mismatch($sformatf("running id got %0d want %0d",
                                      running_task_i, oldest.task_id));
          if (running_valid_i !== oldest.valid)
            report_mismatch($sformatf("running_valid got %0b want %0b",
                                      running_valid_i, oldest.valid));
          if (task_count_i !== oldest.count)
            report_mismatch($sformatf("queued count got %0d want %0d",
                                      task_count_i, oldest.count));
          if (switched_i !== oldest.switched)
            report_mismatch($sformatf("switched got %0b want %0b",
                                      switched_i, oldest.switched));
          if (status_i !== oldest.status)
            report_mismatch($sformatf("status got %0d want %s",
                                      status_i, oldest.status.name()));
        end
        results_seen++;
      end
      if (cfg_we_i) interval_ns = cfg_data_i;
      if (start_i && !busy_i)
        expected_q.push_back(schedule_item(mode_e'(mode_i), task_id_i, elapsed_ns_i));
      pending_count = expected_q.size();
    end
  end

endmodule

>>> tb/round_robin_task_scheduler_core_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the round-robin task scheduler core
// depends on rrts_pkg, the scheduler rtl and rrts_sched_checker
module round_robin_task_scheduler_core_tb import rrts_pkg::*; ();

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 100;
  localparam int PoolSize    = 20;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_data   = '0;
  logic        start      = 1'b0;
  logic        busy;
  mode_e       mode       = MODE_TICK;
  logic [7:0]  task_id    = '0;
  logic [31:0] elapsed_ns = '0;
  logic        done;
  logic [7:0]  run_id;
  logic        running_valid;
  logic [4:0]  queued_cnt;
  logic        switched;
  logic [1:0]  status;

  int          mismatches;
  int          outstanding;
  int unsigned idle_pct     = 0;
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  logic [31:0] cur_interval = IntervalReset;
  logic [7:0]  id_pool [PoolSize];

  round_robin_task_scheduler_core DUT (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .switch_interval_ns_we_i (cfg_we),
    .switch_interval_ns_i    (cfg_data),
    .start                   (start),
    .busy                    (busy),
    .mode_i                  (mode),
    .task_id_i               (task_id),
    .elapsed_ns_i            (elapsed_ns),
    .done_o                  (done),
    .running_task_o          (run_id),
    .running_valid_o         (running_valid),
    .task_count_o            (queued_cnt),
    .switched_o              (switched),
    .status_o                (status)
  );

  rrts_sched_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .start_i         (start),
    .busy_i          (busy),
    .mode_i          (mode),
    .task_id_i       (task_id),
    .elapsed_ns_i    (elapsed_ns),
    .done_i          (done),
    .running_task_i  (run_id),
    .running_valid_i (running_valid),
    .task_count_i    (queued_cnt),
    .switched_i      (switched),
    .status_i        (status),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog on cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // present one item, with an optional random gap first; returns after the
  // accepting edge, leaving start high
  task automatic send_item(mode_e m, logic [7:0] id, logic [31:0] el);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 80 : 8)) @(posedge clk_i);
    end
    start      <= 1'b1;
    mode       <= m;
    task_id    <= id;
    elapsed_ns <= el;
    // busy only moves on a rising edge, so its value at the falling edge
    // decides the next edge
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    items_sent++;
  endtask

  // hold off until every result is in and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic write_interval(logic [31:0] value);
    wait_idle();
    cfg_we       <= 1'b1;
    cfg_data     <= value;
    cur_interval  = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // tick length shaped against the current slice length
  function automatic logic [31:0] slice_step_ns();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 20) return $urandom;
    if (r < 25) return 32'hFFFF_FFFF;
    return $urandom_range(cur_interval / 3 + 1);
  endfunction

  // mostly ids of the pool so adds collide and removes hit
  function automatic logic [7:0] pick_task_id();
    if ($urandom_range(99) < 10) return 8'($urandom_range(255));
    return id_pool[$urandom_range(PoolSize - 1)];
  endfunction

  task automatic random_block(int unsigned n_items, logic [31:0] interval);
    int unsigned target;
    int unsigned pick;
    int          i;
    write_interval(interval);
    for (i = 0; i < PoolSize; i++) id_pool[i] = 8'($urandom_range(255));
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        wait_idle();
      end else if (pick < 3) begin
        // remove every pool id, missing ids included
        for (i = 0; i < PoolSize; i++) send_item(MODE_REMOVE, id_pool[i], $urandom);
      end else if (pick < 37) begin
        send_item(MODE_ADD, pick_task_id(), $urandom);
      end else if (pick < 61) begin
        send_item(MODE_REMOVE, pick_task_id(), $urandom);
      end else if (pick < 88) begin
        send_item(MODE_TICK, 8'($urandom_range(255)), slice_step_ns());
      end else begin
        send_item(MODE_YIELD, 8'($urandom_range(255)), $urandom);
      end
    end
  endtask

  initial begin
    int          k;
    int unsigned blk;
    logic [31:0] interval;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, short slice
    write_interval(32'd100);
    send_item(MODE_TICK, 8'd0, 32'hFFFF_FFFF);    // empty ring keeps no time
    send_item(MODE_YIELD, 8'd0, 32'd0);           // empty ring, no switch
    send_item(MODE_REMOVE, 8'd0, 32'd0);          // missing id
    send_item(MODE_ADD, 8'd0, 32'd0);
    send_item(MODE_TICK, 8'd0, 32'd99);           // just below the slice
    send_item(MODE_TICK, 8'd0, 32'd1);            // single task still switches
    send_item(MODE_ADD, 8'd255, 32'd0);
    send_item(MODE_YIELD, 8'd0, 32'd0);
    send_item(MODE_TICK, 8'd0, 32'hFFFF_FFFF);
    send_item(MODE_TICK, 8'd0, 32'd50);
    send_item(MODE_REMOVE, 8'd0, 32'd0);          // head leaves, slice kept
    send_item(MODE_TICK, 8'd0, 32'd50);
    for (k = 0; k < 15; k++) send_item(MODE_ADD, 8'(k * 16 + 1), 32'd0);
    send_item(MODE_ADD, 8'h80, 32'd0);            // ring full
    send_item(MODE_ADD, 8'd17, 32'd0);            // duplicate while full
    send_item(MODE_REMOVE, 8'd113, 32'd0);        // middle entry closes up
    // zero slice switches on every tick
    write_interval(32'd0);
    send_item(MODE_TICK, 8'hAA, 32'd0);

    // random part: sender gaps 13, then 69, then none
    for (blk = 0; blk < 12; blk++) begin
      idle_pct = (blk < 4) ? 13 : ((blk < 8) ? 69 : 0);
      case (blk % 6)
        0:       interval = 32'd1000;
        1:       interval = 32'd0;
        2:       interval = 32'hFFFF_FFFF;
        3:       interval = 32'd1;
        4:       interval = $urandom_range(2, 200000);
        default: interval = $urandom;
      endcase
      random_block(106, interval);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_ctrl.sv
rtl/core/rrts_dp.sv
rtl/core/round_robin_task_scheduler_core.sv
tb/rrts_sched_checker.sv
tb/round_robin_task_scheduler_core_tb.sv
